[design/fat_table_entry_engine_defines.svh]
`ifndef FAT_TABLE_ENTRY_ENGINE_DEFINES_SVH
`define FAT_TABLE_ENTRY_ENGINE_DEFINES_SVH

// same-cycle check, quiet during reset
`define FTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// next-cycle check, quiet during reset
`define FTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/fte_pkg.sv]
package fte_pkg;

  localparam int unsigned TableBytesDef = 16384;

  localparam logic [27:0] Eoc        = 28'h0FFFFFFF;
  localparam logic [27:0] BadMark    = 28'h0FFFFFF7;
  localparam logic [27:0] Fat32EocLo = 28'h0FFFFFF8;
  localparam logic [11:0] Fat12EocLo = 12'hFF8;
  localparam logic [15:0] Fat16EocLo = 16'hFFF8;

  localparam logic [1:0] KindFat12 = 2'd0;
  localparam logic [1:0] KindFat16 = 2'd1;
  localparam logic [1:0] KindFat32 = 2'd2;

  localparam logic CfgTableKind    = 1'b0;
  localparam logic CfgClusterTotal = 1'b1;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ALLOC = 2'd2,
    CMD_FREE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_CHAIN = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LOAD,
    DP_START_SCAN,
    DP_WRAP,
    DP_NEXT,
    DP_RD_ADDR,
    DP_RD_DATA,
    DP_WR_BYTE,
    DP_TAKE,
    DP_LINK,
    DP_FREE_STEP,
    DP_RESULT
  } dp_cmd_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_WALK,
    S_RD_ADDR,
    S_RD_DATA,
    S_EVAL,
    S_WR,
    S_POST,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_cmd_e cmd;
    status_e st;
  } ctrl_t;

  typedef struct packed {
    cmd_e op;
    logic clr_last;
    logic in_store;
    logic k_last;
    logic norm_zero;
    logic scan_wrap;
    logic scan_full;
    logic walk_end;
    logic steps_over;
    logic has_after;
    logic link;
    logic out_free;
  } dp_stat_t;

  // entry as seen by software, end-of-chain codes folded to one mark
  function automatic logic [27:0] entry_norm(logic [1:0] kind, logic odd, logic [31:0] w);
    logic [11:0] e12;
    logic [27:0] e;
    e12 = odd ? w[15:4] : w[11:0];
    if (kind == KindFat12) begin
      e = (e12 >= Fat12EocLo) ? Eoc : {16'd0, e12};
    end else if (kind == KindFat16) begin
      e = (w[15:0] >= Fat16EocLo) ? Eoc : {12'd0, w[15:0]};
    end else begin
      e = (w[27:0] >= Fat32EocLo) ? Eoc : w[27:0];
    end
    return e;
  endfunction

  // new raw word, neighbor nibble or reserved bits kept
  function automatic logic [31:0] entry_merge(logic [1:0] kind, logic odd, logic [31:0] w,
                                              logic [27:0] v);
    logic [31:0] r;
    if (kind == KindFat12) begin
      r = odd ? {16'd0, v[11:0], w[3:0]} : {16'd0, w[15:12], v[11:0]};
    end else if (kind == KindFat16) begin
      r = {16'd0, v[15:0]};
    end else begin
      r = {w[31:28], v};
    end
    return r;
  endfunction

endpackage

[design/fte_ram.sv]
module fte_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[design/fte_datapath.sv]
module fte_datapath import fte_pkg::*; #(
  parameter int unsigned TableBytes = TableBytesDef,
  localparam int unsigned Aw = $clog2(TableBytes)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [27:0] cfg_data_i,
  input  logic [1:0]  in_command_i,
  input  logic [27:0] in_cluster_i,
  input  logic [27:0] in_value_i,
  input  ctrl_t       ctrl_i,
  output dp_stat_t    stat_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [27:0] out_entry_value_o,
  output logic [1:0]  out_status_o
);

  logic [1:0]  kind_q;
  logic [27:0] total_q, hint_q, after_q, steps_q, taken_q, wval_q;
  logic [28:0] cur_q, start_q;
  logic [31:0] word_q;
  logic [1:0]  k_q;
  logic        phase_q, link_q;
  cmd_e        op_q;
  logic [Aw-1:0] clr_q;
  logic        out_valid_q;
  logic [27:0] out_ev_q;
  status_e     out_st_q;

  logic        wide;
  logic [31:0] off, blen;
  logic        in_store;
  logic [Aw-1:0] byte_addr;
  logic [27:0] norm;
  logic [31:0] merged, merged_sh;
  logic [28:0] last, start_calc;
  logic        ram_we;
  logic [Aw-1:0] ram_waddr;
  logic [7:0]  ram_wdata, ram_rdata;

  assign wide = (kind_q != KindFat12) && (kind_q != KindFat16);

  always_comb begin
    if (kind_q == KindFat12) begin
      off = {3'd0, cur_q} + {4'd0, cur_q[28:1]};
    end else if (kind_q == KindFat16) begin
      off = {2'd0, cur_q, 1'b0};
    end else begin
      off = {1'b0, cur_q, 2'b00};
    end
  end

  assign blen      = wide ? 32'd4 : 32'd2;
  assign in_store  = (off + blen) <= 32'(TableBytes);
  assign byte_addr = off[Aw-1:0] + Aw'(k_q);
  assign norm      = entry_norm(kind_q, cur_q[0], word_q);
  assign merged    = entry_merge(kind_q, cur_q[0], word_q, wval_q);
  assign merged_sh = merged >> {k_q, 3'b000};
  assign last      = {1'b0, total_q} + 29'd1;
  // the hint only seeds the scan for the 32-bit format
  assign start_calc = (wide && hint_q >= 28'd2) ? {1'b0, hint_q} : 29'd2;

  assign ram_we    = (ctrl_i.cmd == DP_CLEAR) || (ctrl_i.cmd == DP_WR_BYTE);
  assign ram_waddr = (ctrl_i.cmd == DP_CLEAR) ? clr_q : byte_addr;
  assign ram_wdata = (ctrl_i.cmd == DP_CLEAR) ? 8'd0 : merged_sh[7:0];

  fte_ram #(
    .Width (8),
    .Depth (TableBytes)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (byte_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    stat_o.op         = op_q;
    stat_o.clr_last   = (clr_q == Aw'(TableBytes - 1));
    stat_o.in_store   = in_store;
    stat_o.k_last     = (k_q == (wide ? 2'd3 : 2'd1));
    stat_o.norm_zero  = (norm == 28'd0);
    stat_o.scan_wrap  = !phase_q && (cur_q > last);
    stat_o.scan_full  = phase_q && (cur_q >= start_q);
    stat_o.walk_end   = (cur_q < 29'd2) || (cur_q >= {1'b0, BadMark});
    stat_o.steps_over = (steps_q >= total_q);
    stat_o.has_after  = (after_q != 28'd0);
    stat_o.link       = link_q;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KindFat32;
      total_q     <= '0;
      hint_q      <= '0;
      clr_q       <= '0;
      k_q         <= '0;
      phase_q     <= 1'b0;
      link_q      <= 1'b0;
      op_q        <= CMD_READ;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgTableKind) begin
          kind_q <= cfg_data_i[1:0];
        end else begin
          total_q <= cfg_data_i;
        end
      end
      if (out_valid_q && !out_stall_i && ctrl_i.cmd != DP_RESULT) begin
        out_valid_q <= 1'b0;
      end
      unique case (ctrl_i.cmd)
        DP_CLEAR: clr_q <= clr_q + Aw'(1);
        DP_LOAD: begin
          op_q    <= cmd_e'(in_command_i);
          phase_q <= 1'b0;
          link_q  <= 1'b0;
        end
        DP_WRAP: phase_q <= 1'b1;
        DP_RD_DATA, DP_WR_BYTE: k_q <= stat_o.k_last ? 2'd0 : k_q + 2'd1;
        DP_TAKE: hint_q <= cur_q[27:0] + 28'd1;
        DP_LINK: link_q <= 1'b1;
        DP_RESULT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      DP_LOAD: begin
        cur_q   <= {1'b0, in_cluster_i};
        after_q <= in_cluster_i;
        wval_q  <= (cmd_e'(in_command_i) == CMD_WRITE) ? in_value_i : 28'd0;
        steps_q <= '0;
      end
      DP_START_SCAN: begin
        cur_q   <= start_calc;
        start_q <= start_calc;
      end
      DP_WRAP: cur_q <= 29'd2;
      DP_NEXT: cur_q <= cur_q + 29'd1;
      DP_RD_DATA: word_q[{k_q, 3'b000} +: 8] <= ram_rdata;
      DP_TAKE: begin
        taken_q <= cur_q[27:0];
        wval_q  <= Eoc;
      end
      DP_LINK: begin
        cur_q  <= {1'b0, after_q};
        wval_q <= taken_q;
      end
      DP_FREE_STEP: begin
        cur_q   <= {1'b0, norm};
        steps_q <= steps_q + 28'd1;
      end
      DP_RESULT: begin
        out_st_q <= ctrl_i.st;
        if (ctrl_i.st == ST_OK && op_q == CMD_READ) begin
          out_ev_q <= norm;
        end else if (ctrl_i.st == ST_OK && op_q == CMD_ALLOC) begin
          out_ev_q <= taken_q;
        end else begin
          out_ev_q <= 28'd0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign out_entry_value_o = out_ev_q;
  assign out_status_o      = out_st_q;

endmodule

[design/fte_ctrl.sv]
module fte_ctrl import fte_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output ctrl_t    ctrl_o
);

  ctrl_state_e state_q, state_d;
  status_e     st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    ctrl_o.cmd = DP_NOP;
    ctrl_o.st  = st_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        ctrl_o.cmd = DP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.cmd = DP_LOAD;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (stat_i.op)
          CMD_READ, CMD_WRITE: begin
            if (!stat_i.in_store) begin
              st_d    = ST_RANGE;
              state_d = S_DONE;
            end else begin
              state_d = S_RD_ADDR;
            end
          end
          CMD_ALLOC: begin
            // link target is checked before anything is scanned
            if (stat_i.has_after && !stat_i.in_store) begin
              st_d    = ST_RANGE;
              state_d = S_DONE;
            end else begin
              ctrl_o.cmd = DP_START_SCAN;
              state_d    = S_SCAN;
            end
          end
          CMD_FREE: state_d = S_WALK;
          default: state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        priority if (stat_i.scan_wrap) begin
          ctrl_o.cmd = DP_WRAP;
        end else if (stat_i.scan_full) begin
          st_d    = ST_FULL;
          state_d = S_DONE;
        end else if (!stat_i.in_store) begin
          st_d    = ST_RANGE;
          state_d = S_DONE;
        end else begin
          state_d = S_RD_ADDR;
        end
      end
      S_WALK: begin
        priority if (stat_i.walk_end) begin
          st_d    = ST_OK;
          state_d = S_DONE;
        end else if (stat_i.steps_over) begin
          st_d    = ST_CHAIN;
          state_d = S_DONE;
        end else if (!stat_i.in_store) begin
          st_d    = ST_RANGE;
          state_d = S_DONE;
        end else begin
          state_d = S_RD_ADDR;
        end
      end
      S_RD_ADDR: begin
        ctrl_o.cmd = DP_RD_ADDR;
        state_d    = S_RD_DATA;
      end
      S_RD_DATA: begin
        ctrl_o.cmd = DP_RD_DATA;
        state_d    = stat_i.k_last ? S_EVAL : S_RD_ADDR;
      end
      S_EVAL: begin
        unique case (stat_i.op)
          CMD_READ: begin
            st_d    = ST_OK;
            state_d = S_DONE;
          end
          CMD_WRITE: state_d = S_WR;
          CMD_ALLOC: begin
            priority if (stat_i.link) begin
              state_d = S_WR;
            end else if (stat_i.norm_zero) begin
              ctrl_o.cmd = DP_TAKE;
              state_d    = S_WR;
            end else begin
              ctrl_o.cmd = DP_NEXT;
              state_d    = S_SCAN;
            end
          end
          CMD_FREE: begin
            if (stat_i.norm_zero) begin
              st_d    = ST_CHAIN;
              state_d = S_DONE;
            end else begin
              state_d = S_WR;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_WR: begin
        ctrl_o.cmd = DP_WR_BYTE;
        if (stat_i.k_last) state_d = S_POST;
      end
      S_POST: begin
        unique case (stat_i.op)
          CMD_ALLOC: begin
            if (!stat_i.link && stat_i.has_after) begin
              ctrl_o.cmd = DP_LINK;
              state_d    = S_RD_ADDR;
            end else begin
              st_d    = ST_OK;
              state_d = S_DONE;
            end
          end
          CMD_FREE: begin
            ctrl_o.cmd = DP_FREE_STEP;
            state_d    = S_WALK;
          end
          default: begin
            st_d    = ST_OK;
            state_d = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.cmd = DP_RESULT;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[design/fat_table_entry_engine.sv]
// read: one read pass over the entry bytes; write: one read pass plus one write pass
// allocate: one read pass per scanned cluster plus the marking and link passes
// free chain: a read pass and a write pass per chain link; entries are 2 or 4 bytes wide
// all table traffic goes one byte at a time through a byte-wide ram with one read and one write port
// after reset a clearing pass zeroes every table byte before a request is taken
// configuration writes are taken at any time, including during the clearing pass
`include "fat_table_entry_engine_defines.svh"

module fat_table_entry_engine import fte_pkg::*; #(
  parameter int unsigned TABLE_BYTES = TableBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [27:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_command_i,
  input  logic [27:0] in_cluster_i,
  input  logic [27:0] in_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [27:0] out_entry_value_o,
  output logic [1:0]  out_status_o
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  fte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  fte_datapath #(
    .TableBytes (TABLE_BYTES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_command_i      (in_command_i),
    .in_cluster_i      (in_cluster_i),
    .in_value_i        (in_value_i),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_entry_value_o (out_entry_value_o),
    .out_status_o      (out_status_o)
  );

  `FTE_ASSERT(a_result_slot_free, (ctrl.cmd == DP_RESULT) |-> stat.out_free, "result overwrites a waiting result")
  `FTE_ASSERT(a_write_in_store, (ctrl.cmd == DP_WR_BYTE) |-> stat.in_store, "table write outside the store")
  `FTE_ASSERT(a_error_zero_value, (out_valid_o && out_status_o != ST_OK) |-> (out_entry_value_o == 28'd0), "error result carries a value")
  `FTE_ASSERT_NEXT(a_result_shown, (ctrl.cmd == DP_RESULT), out_valid_o, "result not presented")

endmodule
